// ===== rtl/core/mpd_pkg.sv =====
// Shared types, constants and codes of the motion presence detector.
package mpd_pkg;

   // Ring depth and derived widths
   localparam int WINDOW_DEPTH = 16;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int WIN_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int FW_W         = 5;
   localparam int CMP_W        = (WIN_W > FW_W) ? WIN_W : FW_W;

   // Field widths
   localparam int SAMPLE_W  = 32;
   localparam int TIME_W    = 32;
   localparam int TMO_S_W   = 12;
   localparam int TMO_MS_W  = 22;
   localparam int PEND_W    = 16;
   localparam int LED_W     = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Timing constants in milliseconds, the second scale and the pending-count limit
   localparam logic [TIME_W-1:0] LED_HOLD_MS   = 32'd3000;
   localparam logic [TIME_W-1:0] REPORT_GAP_MS = 32'd10000;
   localparam int                MS_PER_S      = 1000;
   localparam logic [PEND_W-1:0] PEND_MAX      = 16'hFFFF;

   // Register reset values
   localparam logic [31:0]        MOVE_TH_RST    = 32'd33554;
   localparam logic [31:0]        SOMEONE_TH_RST = 32'd33554;
   localparam logic [FW_W-1:0]    WINDOW_RST     = 5'd5;
   localparam logic [FW_W-1:0]    COUNT_RST      = 5'd2;
   localparam logic [TMO_S_W-1:0] TIMEOUT_RST    = 12'd180;

   // Register indexes
   typedef enum logic [2:0] {
      REG_MOTION_LEVEL     = 3'd0,
      REG_PRESENCE_LEVEL   = 3'd1,
      REG_WINDOW_LEN       = 3'd2,
      REG_HIT_QUOTA        = 3'd3,
      REG_PRESENCE_TIMEOUT = 3'd4,
      REG_CALIBRATE_MODE   = 3'd5
   } reg_index_type;

   // LED commands
   typedef enum logic [LED_W-1:0] {
      LED_NONE   = 3'd0,
      LED_OFF    = 3'd1,
      LED_GREEN  = 3'd2,
      LED_WHITE  = 3'd3,
      LED_YELLOW = 3'd4
   } led_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [SAMPLE_W-1:0] motion_level;
      logic [SAMPLE_W-1:0] presence_level;
      logic [FW_W-1:0]     window_len;
      logic [FW_W-1:0]     hit_quota;
      logic [TMO_S_W-1:0]  presence_timeout_s;
      logic                calibrate_mode;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic step;
      logic decide;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic result_due;
      logic scan_last;
   } status_type;

endpackage

// ===== rtl/core/motion_presence_detector_core.sv =====
// Top level of the motion presence detector: register port, controller and datapath.
// Each jitter sample is written into a window ring of up to 16 entries; until the ring
// holds as many samples as the window length, a transaction gives no result. After that a
// transaction goes through accept, one scan step per window entry (window clamped to 1..16)
// because the ring is compared through a single read port, and decide.
// The result waits in an output register while the next sample is
// taken; a new decision waits only if that register has not yet been emptied.
// Registers (32-bit, byte address 4*index): 0 motion level, 1 calibration presence
// level, 2 window length, 3 hits needed for motion, 4 presence timeout in seconds,
// 5 calibrate mode.
module motion_presence_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   // jitter [31:0], now_ms [63:32]
   input  logic [mpd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // time_synced [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // motion flag [0], presence flag [1], led_action [4:2], presence_report [5],
   // move_report [6], reported_move_flag [7], reported motion tally [23:8]
   output logic [mpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mpd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mpd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mpd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mpd_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type csr_index;
   logic          csr_write;
   cmd_type       cmd;
   status_type    status;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_level       <= MOVE_TH_RST;
         cfg_ff.presence_level     <= SOMEONE_TH_RST;
         cfg_ff.window_len         <= WINDOW_RST;
         cfg_ff.hit_quota          <= COUNT_RST;
         cfg_ff.presence_timeout_s <= TIMEOUT_RST;
         cfg_ff.calibrate_mode     <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MOTION_LEVEL:     cfg_ff.motion_level       <= csr_pwdata;
            REG_PRESENCE_LEVEL:   cfg_ff.presence_level     <= csr_pwdata;
            REG_WINDOW_LEN:       cfg_ff.window_len         <= csr_pwdata[FW_W-1:0];
            REG_HIT_QUOTA:        cfg_ff.hit_quota          <= csr_pwdata[FW_W-1:0];
            REG_PRESENCE_TIMEOUT: cfg_ff.presence_timeout_s <= csr_pwdata[TMO_S_W-1:0];
            REG_CALIBRATE_MODE:   cfg_ff.calibrate_mode     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (csr_index)
         REG_MOTION_LEVEL:     csr_prdata = cfg_ff.motion_level;
         REG_PRESENCE_LEVEL:   csr_prdata = cfg_ff.presence_level;
         REG_WINDOW_LEN:       csr_prdata = CSR_DATA_W'(cfg_ff.window_len);
         REG_HIT_QUOTA:        csr_prdata = CSR_DATA_W'(cfg_ff.hit_quota);
         REG_PRESENCE_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.presence_timeout_s);
         REG_CALIBRATE_MODE:   csr_prdata = CSR_DATA_W'(cfg_ff.calibrate_mode);
         default:              csr_prdata = '0;
      endcase
   end

   mpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mpd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_jitter      (req_tdata[SAMPLE_W-1:0]),
      .req_now_ms      (req_tdata[SAMPLE_W +: TIME_W]),
      .req_time_synced (req_tuser),
      .rsp_data        (rsp_tdata)
   );

endmodule

// ===== rtl/core/mpd_ctrl.sv =====
// Controller state machine: accept, window scan and decision sequencing.
module mpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  mpd_pkg::status_type status,
   output mpd_pkg::cmd_type    cmd
);
   import mpd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Hold state and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one transaction: accept, scan the window, decide
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.result_due) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Set on a new result, drop once taken
   always_comb begin
      if (cmd.decide)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/mpd_datapath.sv =====
// Datapath: sample ring, window scan counter, presence and report state.
module mpd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mpd_pkg::cfg_type                 cfg,
   input  mpd_pkg::cmd_type                 cmd,
   output mpd_pkg::status_type              status,
   input  logic [mpd_pkg::SAMPLE_W-1:0]     req_jitter,
   input  logic [mpd_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                             req_time_synced,
   output logic [mpd_pkg::RSP_DATA_W-1:0]   rsp_data
);
   import mpd_pkg::*;

   // Window state
   logic [SAMPLE_W-1:0] ring_ff [WINDOW_DEPTH];
   logic [IDX_W-1:0]    write_pos_ff, write_pos_in;
   logic [WIN_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    scan_idx_ff;
   logic [WIN_W-1:0]    hits_ff;

   // Latched transaction
   logic [SAMPLE_W-1:0] jitter_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                synced_ff;
   logic [TMO_MS_W-1:0] timeout_ms_ff;

   // Decision state
   logic                blink_ff, blink_in;
   logic [TIME_W-1:0]   last_motion_ff, last_motion_in;
   logic                prev_move_ff, prev_move_in;
   logic                sent_presence_ff, sent_presence_in;
   logic                sent_move_ff, sent_move_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;
   logic [TIME_W-1:0]   last_report_ff, last_report_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Effective window and write slot
   logic [CMP_W-1:0] fw_ext;
   logic [CMP_W-1:0] win_cmp;
   logic [WIN_W-1:0] win;
   logic [IDX_W-1:0] wr_slot;
   logic [WIN_W-1:0] wr_next;

   always_comb begin
      fw_ext = CMP_W'(cfg.window_len);
      if (fw_ext == '0)                           win_cmp = CMP_W'(1);
      else if (fw_ext > CMP_W'(WINDOW_DEPTH))     win_cmp = CMP_W'(WINDOW_DEPTH);
      else                                        win_cmp = fw_ext;
      win = WIN_W'(win_cmp);

      wr_slot = (WIN_W'(write_pos_ff) >= win) ? '0 : write_pos_ff;
      wr_next = WIN_W'(wr_slot) + WIN_W'(1);
      write_pos_in = (wr_next >= win) ? '0 : IDX_W'(wr_next);
      fill_in = (fill_ff < WIN_W'(WINDOW_DEPTH)) ? fill_ff + WIN_W'(1) : fill_ff;

      status.result_due = (fill_in >= win);
      status.scan_last  = (WIN_W'(scan_idx_ff) == win - WIN_W'(1));
   end

   // Write the ring and latch the transaction on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) ring_ff[i] <= '0;
         write_pos_ff <= '0;
         fill_ff      <= '0;
      end else if (cmd.accept) begin
         ring_ff[wr_slot] <= req_jitter;
         write_pos_ff     <= write_pos_in;
         fill_ff          <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         jitter_ff     <= req_jitter;
         now_ff        <= req_now_ms;
         synced_ff     <= req_time_synced;
         timeout_ms_ff <= TMO_MS_W'(cfg.presence_timeout_s * MS_PER_S);
      end
   end

   // Walk the window one entry a cycle, counting entries above threshold
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         scan_idx_ff <= '0;
         hits_ff     <= '0;
      end else if (cmd.step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (ring_ff[scan_idx_ff] > cfg.motion_level) hits_ff <= hits_ff + WIN_W'(1);
      end
   end

   // Decide presence, LED command and reports
   logic                move;
   logic                someone;
   led_type             led;
   logic                p_rep, m_rep, r_flag;
   logic [PEND_W-1:0]   r_count;
   logic [TIME_W-1:0]   since;
   logic [TIME_W-1:0]   gap;
   logic [PEND_W-1:0]   pend_inc;

   always_comb begin
      move     = (CMP_W'(hits_ff) >= CMP_W'(cfg.hit_quota));
      since    = now_ff - last_motion_ff;
      gap      = now_ff - last_report_ff;
      pend_inc = (move && pending_ff != PEND_MAX) ? pending_ff + PEND_W'(1) : pending_ff;

      someone          = 1'b0;
      led              = LED_NONE;
      p_rep            = 1'b0;
      m_rep            = 1'b0;
      r_flag           = 1'b0;
      r_count          = '0;
      blink_in         = blink_ff;
      last_motion_in   = last_motion_ff;
      prev_move_in     = prev_move_ff;
      sent_presence_in = sent_presence_ff;
      sent_move_in     = sent_move_ff;
      pending_in       = pending_ff;
      last_report_in   = last_report_ff;

      if (cfg.calibrate_mode) begin
         // Blink yellow, raw presence compare
         someone  = (jitter_ff > cfg.presence_level);
         led      = blink_ff ? LED_OFF : LED_YELLOW;
         blink_in = ~blink_ff;
      end else begin
         someone = (since < TIME_W'(timeout_ms_ff));
         if (move) begin
            if (!prev_move_ff) led = LED_GREEN;
            last_motion_in = now_ff;
         end else if (prev_move_ff) begin
            led = LED_NONE;
         end else if (since > LED_HOLD_MS) begin
            led = someone ? LED_WHITE : LED_OFF;
         end
         prev_move_in = move;

         if (synced_ff) begin
            pending_in = pend_inc;
            if (sent_presence_ff && !someone) begin
               p_rep            = 1'b1;
               sent_presence_in = 1'b0;
            end
            if ((move != sent_move_ff) || (move && gap > REPORT_GAP_MS)) begin
               m_rep            = 1'b1;
               sent_presence_in = someone;
               r_flag           = move || (pend_inc != '0);
               r_count          = pend_inc;
               if (!sent_move_ff || pend_inc == '0) sent_move_in = move;
               pending_in       = '0;
               last_report_in   = now_ff;
            end
         end
      end

      rsp_data_in = {r_count, r_flag, m_rep, p_rep, led, someone, move};
   end

   // Commit decision state on decide
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff         <= 1'b0;
         last_motion_ff   <= '0;
         prev_move_ff     <= 1'b0;
         sent_presence_ff <= 1'b0;
         sent_move_ff     <= 1'b0;
         pending_ff       <= '0;
         last_report_ff   <= '0;
      end else if (cmd.decide) begin
         blink_ff         <= blink_in;
         last_motion_ff   <= last_motion_in;
         prev_move_ff     <= prev_move_in;
         sent_presence_ff <= sent_presence_in;
         sent_move_ff     <= sent_move_in;
         pending_ff       <= pending_in;
         last_report_ff   <= last_report_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.decide) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/core/mpd_checker.sv =====
// Port-level checker for the motion presence detector, bound to the top level.
module mpd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mpd_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // LED command stays within its codes
   a_led_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:2] == LED_NONE || rsp_tdata[4:2] == LED_OFF ||
                      rsp_tdata[4:2] == LED_GREEN || rsp_tdata[4:2] == LED_WHITE ||
                      rsp_tdata[4:2] == LED_YELLOW))
      else $error("LED command out of range");

   // Report values only travel with a motion report
   a_no_report_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> !rsp_tdata[7] && rsp_tdata[23:8] == '0)
      else $error("motion report value without a motion report");

   // A presence-lost report means no presence
   a_presence_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> !rsp_tdata[1])
      else $error("presence-lost report while present");

endmodule

bind motion_presence_detector_core mpd_checker u_mpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/testbench.sv =====
// Self-checking bench for the motion presence detector: directed table, random phases, steady motion.
module testbench;
   import mpd_pkg::*;

   // Result as it travels on rsp_tdata, lowest field last
   typedef struct packed {
      logic [PEND_W-1:0] motion_tally;
      logic              move_flag;
      logic              move_report;
      logic              presence_report;
      led_type           led;
      logic              someone;
      logic              moving;
   } detection_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type idx;
      logic [31:0]   value;
      logic [31:0]   jit;
      logic [31:0]   now;
      logic          synced;
      bit            fixed;
      detection_type fixed_d;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   motion_presence_detector_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Shadow of the detector: configuration and state
   cfg_type           shadow_cfg;
   logic [31:0]       ring [WINDOW_DEPTH];
   int                ring_pos;
   int                fill_level;
   logic              blink;
   logic [31:0]       last_motion;
   logic              prev_mv;
   logic              sent_pres;
   logic              sent_mv;
   logic [PEND_W-1:0] pend;
   logic [31:0]       last_report;

   detection_type detections_due [$];
   plan_row_type  plan [$];

   bit          quiet       = 1'b0;
   bit          motion_high = 1'b0;
   int unsigned mismatches  = 0;
   int unsigned samples_sent = 0;
   int unsigned results_checked = 0;
   int unsigned motion_reports = 0;
   int unsigned presence_lost = 0;
   int unsigned blink_results = 0;
   int unsigned settings_applied = 0;
   int unsigned peak_count = 0;
   detection_type seen;
   detection_type want;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40)
         $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int exp_val);
      if (got != exp_val)
         report_mismatch($sformatf("%s got %0d, expected %0d (result %0d)",
                                   name, got, exp_val, results_checked));
   endtask

   function automatic void reset_shadow();
      shadow_cfg.motion_level       = MOVE_TH_RST;
      shadow_cfg.presence_level     = SOMEONE_TH_RST;
      shadow_cfg.window_len         = WINDOW_RST;
      shadow_cfg.hit_quota          = COUNT_RST;
      shadow_cfg.presence_timeout_s = TIMEOUT_RST;
      shadow_cfg.calibrate_mode     = 1'b0;
      foreach (ring[i])
         ring[i] = '0;
      ring_pos    = 0;
      fill_level  = 0;
      blink       = 1'b0;
      last_motion = '0;
      prev_mv     = 1'b0;
      sent_pres   = 1'b0;
      sent_mv     = 1'b0;
      pend        = '0;
      last_report = '0;
   endfunction

   // Advance the shadow by one sample; returns 1 when a result is due
   function automatic bit predict_detection(input logic [31:0] jit, input logic [31:0] now,
                                            input logic synced, output detection_type d);
      int          win;
      int          hits;
      logic        mv;
      logic        pres;
      logic [31:0] since;
      logic [31:0] hold_ms;
      d    = '0;
      hits = 0;
      win  = int'(shadow_cfg.window_len);
      if (win == 0)
         win = 1;
      if (win > WINDOW_DEPTH)
         win = WINDOW_DEPTH;
      if (ring_pos >= win)
         ring_pos = 0;
      ring[ring_pos] = jit;
      ring_pos = (ring_pos + 1 >= win) ? 0 : ring_pos + 1;
      if (fill_level < WINDOW_DEPTH)
         fill_level++;
      if (fill_level < win)
         return 1'b0;

      // Count window entries strictly above the move threshold
      for (int i = 0; i < win; i++)
         if (ring[i] > shadow_cfg.motion_level)
            hits++;
      mv = (hits >= int'(shadow_cfg.hit_quota));
      d.moving = mv;

      if (shadow_cfg.calibrate_mode) begin
         d.someone = (jit > shadow_cfg.presence_level);
         d.led     = blink ? LED_OFF : LED_YELLOW;
         blink     = ~blink;
         return 1'b1;
      end

      // Presence holds for the timeout after the last motion
      since   = now - last_motion;
      hold_ms = shadow_cfg.presence_timeout_s * MS_PER_S;
      pres    = (since < hold_ms);
      d.someone = pres;
      if (mv) begin
         if (!prev_mv)
            d.led = LED_GREEN;
         last_motion = now;
      end else if (prev_mv) begin
         d.led = LED_NONE;
      end else if (since > LED_HOLD_MS) begin
         d.led = pres ? LED_WHITE : LED_OFF;
      end
      prev_mv = mv;

      // Throttled reports, only while wall time is valid
      if (synced) begin
         if (mv && pend != PEND_MAX)
            pend = pend + 1'b1;
         if (sent_pres != pres && !pres) begin
            d.presence_report = 1'b1;
            sent_pres = pres;
         end
         if (mv != sent_mv || (mv && (now - last_report) > REPORT_GAP_MS)) begin
            d.move_report  = 1'b1;
            sent_pres      = pres;
            d.move_flag    = mv || (pend != '0);
            d.motion_tally = pend;
            if (!sent_mv || pend == '0)
               sent_mv = mv;
            pend        = '0;
            last_report = now;
         end
      end
      return 1'b1;
   endfunction

   function automatic detection_type fixed_result(input logic mv, input logic pres,
                                                  input led_type led,
                                                  input logic prep, input logic mrep,
                                                  input logic flag,
                                                  input logic [PEND_W-1:0] cnt);
      detection_type d;
      d.moving          = mv;
      d.someone         = pres;
      d.led             = led;
      d.presence_report = prep;
      d.move_report     = mrep;
      d.move_flag       = flag;
      d.motion_tally    = cnt;
      return d;
   endfunction

   function automatic void add_sample(input logic [31:0] jit, input logic [31:0] now,
                                      input logic synced);
      plan_row_type r;
      r.kind    = ROW_SAMPLE;
      r.idx     = REG_MOTION_LEVEL;
      r.value   = '0;
      r.jit     = jit;
      r.now     = now;
      r.synced  = synced;
      r.fixed   = 1'b0;
      r.fixed_d = '0;
      plan.push_back(r);
   endfunction

   function automatic void add_fixed(input logic [31:0] jit, input logic [31:0] now,
                                     input logic synced, input detection_type d);
      add_sample(jit, now, synced);
      plan[plan.size() - 1].fixed   = 1'b1;
      plan[plan.size() - 1].fixed_d = d;
   endfunction

   function automatic void add_write(input reg_index_type idx, input logic [31:0] value);
      plan_row_type r;
      r.kind    = ROW_WRITE;
      r.idx     = idx;
      r.value   = value;
      r.jit     = '0;
      r.now     = '0;
      r.synced  = 1'b0;
      r.fixed   = 1'b0;
      r.fixed_d = '0;
      plan.push_back(r);
   endfunction

   // Register write: setup cycle, then access cycle until pready
   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MOTION_LEVEL:     shadow_cfg.motion_level       = value;
         REG_PRESENCE_LEVEL:   shadow_cfg.presence_level     = value;
         REG_WINDOW_LEN:       shadow_cfg.window_len         = value[FW_W-1:0];
         REG_HIT_QUOTA:        shadow_cfg.hit_quota          = value[FW_W-1:0];
         REG_PRESENCE_TIMEOUT: shadow_cfg.presence_timeout_s = value[TMO_S_W-1:0];
         REG_CALIBRATE_MODE:   shadow_cfg.calibrate_mode     = value[0];
         default: ;
      endcase
   endtask

   // Offer one sample after a random gap and record what it should produce
   task automatic send_sample(input logic [31:0] jit, input logic [31:0] now,
                              input logic synced, input bit fixed,
                              input detection_type fixed_d);
      int            gap;
      detection_type d;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {now, jit};
      req_tuser  <= synced;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (predict_detection(jit, now, synced, d))
         detections_due.push_back(fixed ? fixed_d : d);
   endtask

   // Drop valid, wait for every pending result, then let a sample with no result finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (detections_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] next_jitter();
      logic [31:0] th;
      logic [31:0] room;
      th = shadow_cfg.motion_level;
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      if ($urandom_range(0, 4) == 0)
         return $urandom >> $urandom_range(0, 31);
      if (motion_high && $urandom_range(0, 4) != 0) begin
         if (th == 32'hFFFF_FFFF)
            return th;
         room = ~th;
         return th + 32'd1 + $urandom_range(0, (room > 32'd1000) ? 1000 : room - 32'd1);
      end
      if ($urandom_range(0, 3) == 0)
         return th;
      return $urandom_range(0, th);
   endfunction

   function automatic logic [31:0] random_threshold();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return MOVE_TH_RST;
         default: return $urandom_range(0, 32'h0400_0000);
      endcase
   endfunction

   // Result consumer: random stall before each transaction, none while quiet
   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = detection_type'(rsp_tdata);
         if (detections_due.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
         end else begin
            want = detections_due.pop_front();
            check_field("motion flag", int'(seen.moving), int'(want.moving));
            check_field("presence flag", int'(seen.someone), int'(want.someone));
            check_field("led_action", int'(seen.led), int'(want.led));
            check_field("presence_report", int'(seen.presence_report),
                        int'(want.presence_report));
            check_field("move_report", int'(seen.move_report), int'(want.move_report));
            check_field("reported_move_flag", int'(seen.move_flag), int'(want.move_flag));
            check_field("reported tally", int'(seen.motion_tally), int'(want.motion_tally));
            if (want.move_report)
               motion_reports++;
            if (want.presence_report)
               presence_lost++;
            if (want.led == LED_YELLOW)
               blink_results++;
            if (want.motion_tally > peak_count)
               peak_count = want.motion_tally;
         end
         results_checked++;
      end
   end

   // Stimulus
   initial begin
      logic [31:0] now;
      logic [31:0] frozen_ms;
      int unsigned step_ms;
      int          win;
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table: fill, first motion, reports, wrap, calibration, window limits
      add_sample(32'h0, 32'd0, 1'b0);
      add_sample(32'h0, 32'd0, 1'b0);
      add_sample(32'h0, 32'd0, 1'b0);
      add_sample(32'h0, 32'd0, 1'b0);
      add_fixed(32'h0, 32'd0, 1'b0,
                fixed_result(1'b0, 1'b1, LED_NONE, 1'b0, 1'b0, 1'b0, 16'd0));
      add_fixed(32'hFFFF_FFFF, 32'd1000, 1'b1,
                fixed_result(1'b0, 1'b1, LED_NONE, 1'b0, 1'b0, 1'b0, 16'd0));
      add_fixed(32'hFFFF_FFFF, 32'd2000, 1'b1,
                fixed_result(1'b1, 1'b1, LED_GREEN, 1'b0, 1'b1, 1'b1, 16'd1));
      add_sample(32'hFFFF_FFFF, 32'd15000, 1'b1);
      add_sample(32'h0, 32'd16000, 1'b0);
      add_sample(32'h0, 32'd17000, 1'b1);
      add_sample(32'h0, 32'd18000, 1'b1);
      add_sample(MOVE_TH_RST, 32'd19000, 1'b1);
      add_sample(32'h0, 32'd300000, 1'b1);
      add_sample(32'h0, 32'hFFFF_FF00, 1'b1);
      add_sample(32'h8000_0000, 32'h0000_0100, 1'b1);
      add_write(REG_CALIBRATE_MODE, 32'd1);
      add_write(REG_PRESENCE_LEVEL, 32'h0100_0000);
      add_sample(32'h0100_0000, 32'd500, 1'b1);
      add_sample(32'h0100_0001, 32'd600, 1'b1);
      add_write(REG_CALIBRATE_MODE, 32'd0);
      add_write(REG_WINDOW_LEN, 32'd0);
      add_write(REG_HIT_QUOTA, 32'd0);
      add_sample(32'h0, 32'd700, 1'b1);
      add_sample(32'h0, 32'd800, 1'b0);
      add_write(REG_WINDOW_LEN, 32'd31);
      add_write(REG_HIT_QUOTA, 32'd17);
      add_write(REG_MOTION_LEVEL, 32'h0);
      add_sample(32'h1, 32'd900, 1'b1);
      add_sample(32'hFFFF_FFFF, 32'd1000, 1'b1);
      add_write(REG_PRESENCE_TIMEOUT, 32'd0);
      add_write(REG_HIT_QUOTA, 32'd16);
      add_sample(32'h5, 32'd1100, 1'b1);
      add_write(REG_PRESENCE_TIMEOUT, 32'd4095);
      add_write(REG_MOTION_LEVEL, 32'hFFFF_FFFF);
      add_write(REG_WINDOW_LEN, 32'd16);
      add_write(REG_HIT_QUOTA, 32'd1);
      add_sample(32'hFFFF_FFFF, 32'd1200, 1'b1);
      add_sample(32'h7FFF_FFFF, 32'd2000000, 1'b1);

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_WRITE) begin
            settle();
            write_csr(plan[k].idx, plan[k].value);
         end else begin
            send_sample(plan[k].jit, plan[k].now, plan[k].synced,
                        plan[k].fixed, plan[k].fixed_d);
         end
      end
      settle();
      settings_applied = 1;

      // Random phases, each under a fresh register setting; first two at the extremes
      for (int p = 0; p < 8; p++) begin
         if (p == 0) begin
            write_csr(REG_MOTION_LEVEL, 32'h0);
            write_csr(REG_PRESENCE_LEVEL, 32'h0);
            write_csr(REG_WINDOW_LEN, 32'd1);
            write_csr(REG_HIT_QUOTA, 32'd1);
            write_csr(REG_PRESENCE_TIMEOUT, 32'd10);
            write_csr(REG_CALIBRATE_MODE, 32'd0);
         end else if (p == 1) begin
            write_csr(REG_MOTION_LEVEL, 32'hFFFF_FFFF);
            write_csr(REG_PRESENCE_LEVEL, 32'hFFFF_FFFF);
            write_csr(REG_WINDOW_LEN, 32'd16);
            write_csr(REG_HIT_QUOTA, 32'd16);
            write_csr(REG_PRESENCE_TIMEOUT, 32'd4095);
            write_csr(REG_CALIBRATE_MODE, 32'd1);
         end else begin
            win = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(0, 31);
            write_csr(REG_MOTION_LEVEL, random_threshold());
            write_csr(REG_PRESENCE_LEVEL, random_threshold());
            write_csr(REG_WINDOW_LEN, win);
            write_csr(REG_HIT_QUOTA, ($urandom_range(0, 99) < 80) ?
                      $urandom_range(1, (win < 1) ? 1 : (win > 16 ? 16 : win)) :
                      $urandom_range(0, 31));
            write_csr(REG_PRESENCE_TIMEOUT, ($urandom_range(0, 99) < 80) ?
                      $urandom_range(10, 60) : $urandom_range(0, 4095));
            write_csr(REG_CALIBRATE_MODE, ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);
         end
         settings_applied++;
         now = $urandom;
         for (int n = 0; n < 115; n++) begin
            if ($urandom_range(0, 11) == 0)
               motion_high = ~motion_high;
            if ($urandom_range(0, 24) == 0)
               quiet = ~quiet;
            case ($urandom_range(0, 99)) inside
               [0:69]:  step_ms = $urandom_range(0, 1500);
               [70:89]: step_ms = $urandom_range(0, 20000);
               [90:97]: step_ms = shadow_cfg.presence_timeout_s * MS_PER_S +
                                  $urandom_range(0, 5000);
               default: step_ms = $urandom;
            endcase
            now = now + step_ms;
            send_sample(next_jitter(), now, ($urandom_range(0, 99) < 85), 1'b0, '0);
         end
         quiet = 1'b0;
         settle();
      end

      // Steady motion at a frozen clock builds up a pending count, then one late report
      write_csr(REG_WINDOW_LEN, 32'd1);
      write_csr(REG_HIT_QUOTA, 32'd0);
      write_csr(REG_CALIBRATE_MODE, 32'd0);
      settings_applied++;
      quiet     = 1'b1;
      frozen_ms = last_report;
      for (int n = 0; n < 40; n++)
         send_sample($urandom, frozen_ms, 1'b1, 1'b0, '0);
      send_sample($urandom, frozen_ms + 32'd20000, 1'b1, 1'b0, '0);
      quiet = 1'b0;
      settle();

      $display("Covered %0d samples under %0d register settings; %0d results checked",
               samples_sent, settings_applied, results_checked);
      $display("%0d motion reports (peak count %0d), %0d presence-lost, %0d yellow blinks",
               motion_reports, peak_count, presence_lost, blink_results);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #(8 * 500000);
      $display("Timeout: run did not finish, %0d results still due", detections_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
